### hw/rtl/rrhc_pkg.sv
// Shared types, codes and byte positions for the radar record header checker.
package rrhc_pkg;

  localparam int HEADER_BYTES_DEF = 40;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 208;

  // Status codes of the verdict.
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_UNCHECKED  = 4'd1;
  localparam logic [3:0] ST_HDR_KIND   = 4'd2;
  localparam logic [3:0] ST_TYPE2      = 4'd3;
  localparam logic [3:0] ST_TYPE1      = 4'd4;
  localparam logic [3:0] ST_REGION     = 4'd5;
  localparam logic [3:0] ST_NO_END     = 4'd6;
  localparam logic [3:0] ST_SHORT      = 4'd7;
  localparam logic [3:0] ST_NO_START   = 4'd8;
  localparam logic [3:0] ST_BAD_COUNT  = 4'd9;
  localparam logic [3:0] ST_BAD_SIZE   = 4'd10;
  localparam logic [3:0] ST_LAST_CODE  = ST_BAD_SIZE;

  // Code bytes.
  localparam logic [7:0] START_CODE  = 8'hFD;
  localparam logic [7:0] END_CODE    = 8'hFE;
  localparam logic [7:0] REGION_CODE = 8'h70;
  localparam logic [7:0] TYPE1_CODE  = 8'hC0;
  localparam logic [7:0] TYPE2_CODE_A = 8'h01;
  localparam logic [7:0] TYPE2_CODE_B = 8'h05;
  localparam logic [7:0] KIND_SHORT  = 8'h00;
  localparam logic [7:0] KIND_LONG   = 8'h01;

  localparam logic [6:0] OFFSET_KIND_SHORT = 7'd32;
  localparam logic [6:0] OFFSET_KIND_LONG  = 7'd64;

  // Length thresholds, in bytes.
  localparam int MIN_LEN   = 32;
  localparam int COUNT_LEN = 36;

  // Byte positions inside the header.
  localparam int B_START  = 0;
  localparam int B_REGION = 1;
  localparam int B_TYPE1  = 2;
  localparam int B_TYPE2  = 3;
  localparam int B_KIND   = 6;
  localparam int B_TIME   = 8;
  localparam int TIME_BYTES = 16;
  localparam int B_COUNT  = 34;
  localparam int B_SIZE   = 36;

  // Header bytes the verdict looks at.
  typedef struct packed {
    logic [7:0]   start;
    logic [7:0]   region;
    logic [7:0]   type1;
    logic [7:0]   type2;
    logic [7:0]   kind;
    logic [127:0] time_text;
    logic [7:0]   cnt_hi;
    logic [7:0]   cnt_lo;
    logic [7:0]   size_b3;
    logic [7:0]   size_b2;
    logic [7:0]   size_b1;
    logic [7:0]   size_b0;
  } rrhc_hdr_t;

  // Result beat, laid out so that status sits in the lowest bits of tdata.
  typedef struct packed {
    logic [4:0]  pad;
    logic [63:0] time_text_low;
    logic [63:0] time_text_high;
    logic [6:0]  first_block_offset;
    logic        total_size_present;
    logic [30:0] total_size;
    logic        block_count_present;
    logic [14:0] block_count;
    logic [15:0] data_type;
    logic [3:0]  status;
  } rrhc_result_t;

endpackage

### hw/rtl/rrhc_judge.sv
// Verdict logic: checks the captured header bytes and forms one result beat.
module rrhc_judge #(
  parameter int HEADER_BYTES = rrhc_pkg::HEADER_BYTES_DEF
) (
  input  rrhc_pkg::rrhc_hdr_t    hdr_i,
  input  logic [32:0]            len_i,
  input  logic [HEADER_BYTES-1:0] end_flags_i,
  input  logic [7:0]             far_end_i,
  output rrhc_pkg::rrhc_result_t res_o
);
  import rrhc_pkg::*;

  localparam int IDX_W = $clog2(HEADER_BYTES);

  logic [30:0]      size;
  logic [30:0]      size_m1;
  logic [IDX_W-1:0] end_idx;
  logic [3:0]       warn;
  logic [6:0]       offset;
  logic             len_count;
  logic             len_header;
  logic             fatal;
  logic             end_ok;
  logic             unchecked;

  assign size       = {hdr_i.size_b3[6:0], hdr_i.size_b2, hdr_i.size_b1, hdr_i.size_b0};
  assign size_m1    = size - 31'd1;
  assign end_idx    = size_m1[IDX_W-1:0];
  assign len_count  = len_i >= 33'(COUNT_LEN);
  assign len_header = len_i >= 33'(HEADER_BYTES);

  // The most severe warning wins; codes rise with severity.
  always_comb begin
    offset = 7'd0;
    if (hdr_i.kind == KIND_SHORT) begin
      offset = OFFSET_KIND_SHORT;
    end else if (hdr_i.kind == KIND_LONG) begin
      offset = OFFSET_KIND_LONG;
    end
    priority if (hdr_i.region != REGION_CODE) begin
      warn = ST_REGION;
    end else if (hdr_i.type1 != TYPE1_CODE) begin
      warn = ST_TYPE1;
    end else if (hdr_i.type2 != TYPE2_CODE_A && hdr_i.type2 != TYPE2_CODE_B) begin
      warn = ST_TYPE2;
    end else if (hdr_i.kind != KIND_SHORT && hdr_i.kind != KIND_LONG) begin
      warn = ST_HDR_KIND;
    end else begin
      warn = ST_OK;
    end
  end

  always_comb begin
    res_o     = '0;
    fatal     = 1'b0;
    end_ok    = 1'b0;
    unchecked = 1'b0;
    priority if (hdr_i.start != START_CODE) begin
      res_o.status = ST_NO_START;
    end else if (len_i < 33'(MIN_LEN)) begin
      res_o.status = ST_SHORT;
    end else begin
      if (len_count) begin
        if (hdr_i.cnt_hi[7]) begin
          res_o.status = ST_BAD_COUNT;
          fatal        = 1'b1;
        end else begin
          res_o.block_count         = {hdr_i.cnt_hi[6:0], hdr_i.cnt_lo};
          res_o.block_count_present = 1'b1;
        end
      end
      if (!fatal && len_header) begin
        if (hdr_i.size_b3[7] || size == 31'd0) begin
          res_o.status = ST_BAD_SIZE;
          fatal        = 1'b1;
        end else begin
          res_o.total_size         = size;
          res_o.total_size_present = 1'b1;
        end
      end
      if (!fatal) begin
        if (len_header && len_i >= {2'b00, size}) begin
          // A short record ends inside the header; a long one at a byte
          // captured on the fly.
          if (size <= 31'(HEADER_BYTES)) begin
            end_ok = end_flags_i[end_idx];
          end else begin
            end_ok = far_end_i == END_CODE;
          end
          if (!end_ok) begin
            res_o.status = ST_NO_END;
            fatal        = 1'b1;
          end
        end else begin
          unchecked = 1'b1;
        end
      end
      if (!fatal) begin
        if (warn != ST_OK) begin
          res_o.status = warn;
        end else if (unchecked) begin
          res_o.status = ST_UNCHECKED;
        end else begin
          res_o.status = ST_OK;
        end
        res_o.data_type          = {hdr_i.type1, hdr_i.type2};
        res_o.first_block_offset = offset;
        res_o.time_text_high     = hdr_i.time_text[127:64];
        res_o.time_text_low      = hdr_i.time_text[63:0];
      end
    end
  end

endmodule

### hw/rtl/radar_record_header_check.sv
// Top level of the radar record header checker: byte intake, header capture, result register.
//
// The slave side takes one record buffer as a stream of byte beats on in_tdata, with
// in_tlast high on the final byte of the buffer; the beat after it starts a new buffer.
// For every buffer, one result beat leaves on the master side when the final byte has
// been processed. Beats that are not the final byte of a buffer produce no result.
//
// A final byte accepted into the input register has its result beat loaded into the result
// register once that register is free. Throughput is one byte per cycle while no final
// byte waits for the result register; the byte position counter and the per-position
// compares set that figure, and every byte is handled in a single pass between the input
// register and the result register.
//
// When the receiver stalls, the result register holds its beat and the block keeps
// taking bytes that are not final; a final byte waits in the input register until
// the result register is free, and in_tready stays low while it waits.
//
// Reset (rst_n low, synchronous) empties both registers and rewinds the byte position
// to the start of a buffer. The captured header bytes need no reset: every byte read
// for a verdict has been written earlier in the same buffer.
module radar_record_header_check #(
  parameter int HEADER_BYTES = rrhc_pkg::HEADER_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [rrhc_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] data_byte
  input  logic                               in_tlast,   // last_byte
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata, from bit 0 up: status[3:0], data_type[19:4], block_count[34:20],
  // block_count_present[35], total_size[66:36], total_size_present[67],
  // first_block_offset[74:68], time_text_high[138:75], time_text_low[202:139],
  // zero fill[207:203].
  output logic [rrhc_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import rrhc_pkg::*;

  // Input register.
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;

  // Per-buffer state.
  logic [31:0] pos_r;
  logic [31:0] pos_nxt;
  logic [7:0]  hdr_r [HEADER_BYTES];
  logic [7:0]  cand_r;
  logic        seen_r;

  // Result register.
  logic         out_valid_r;
  rrhc_result_t out_data_r;

  logic                    out_free;
  logic                    adv;
  logic [32:0]             len;
  logic [HEADER_BYTES-1:0] hit;
  logic [7:0]              view [HEADER_BYTES];
  logic [HEADER_BYTES-1:0] end_flags;
  logic [30:0]             size;
  logic                    cap_now;
  logic [7:0]              far_end;
  rrhc_hdr_t               hdr;
  rrhc_result_t            res;

  // A final byte moves on only when the result register can take its verdict.
  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready = !s1_valid_r || adv;

  // Length of the buffer if the byte in the input register is its last one.
  assign len     = {1'b0, pos_r} + 33'd1;
  assign pos_nxt = len[32] ? pos_r : len[31:0];

  // The header as it stands with the current byte written in.
  always_comb begin
    for (int k = 0; k < HEADER_BYTES; k++) begin
      hit[k]       = pos_r == 32'(k);
      view[k]      = hit[k] ? s1_byte_r : hdr_r[k];
      end_flags[k] = view[k] == END_CODE;
    end
  end

  assign size = {view[B_SIZE][6:0], view[B_SIZE+1], view[B_SIZE+2], view[B_SIZE+3]};

  // Past the header, the byte at position size-1 is kept as the end code candidate.
  assign cap_now = (pos_r >= 32'(HEADER_BYTES)) && (len == {2'b00, size}) &&
                   !view[B_SIZE][7];
  assign far_end = cap_now ? s1_byte_r : (seen_r ? cand_r : 8'h00);

  always_comb begin
    hdr.start   = view[B_START];
    hdr.region  = view[B_REGION];
    hdr.type1   = view[B_TYPE1];
    hdr.type2   = view[B_TYPE2];
    hdr.kind    = view[B_KIND];
    for (int k = 0; k < TIME_BYTES; k++) begin
      hdr.time_text[127 - 8*k -: 8] = view[B_TIME + k];
    end
    hdr.cnt_hi  = view[B_COUNT];
    hdr.cnt_lo  = view[B_COUNT+1];
    hdr.size_b3 = view[B_SIZE];
    hdr.size_b2 = view[B_SIZE+1];
    hdr.size_b1 = view[B_SIZE+2];
    hdr.size_b0 = view[B_SIZE+3];
  end

  rrhc_judge #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_judge (
    .hdr_i       (hdr),
    .len_i       (len),
    .end_flags_i (end_flags),
    .far_end_i   (far_end),
    .res_o       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      seen_r <= 1'b0;
    end else if (adv) begin
      if (s1_last_r) begin
        pos_r  <= '0;
        seen_r <= 1'b0;
      end else begin
        pos_r <= pos_nxt;
        if (cap_now) begin
          seen_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (cap_now) begin
        cand_r <= s1_byte_r;
      end
      for (int k = 0; k < HEADER_BYTES; k++) begin
        if (hit[k]) begin
          hdr_r[k] <= s1_byte_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_last_r) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### hw/rtl/rrhc_checker.sv
// Port-level checker for the radar record header checker, bound to the top level.
module rrhc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             in_tlast,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rrhc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import rrhc_pkg::*;

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Status never carries a code beyond the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= ST_LAST_CODE)
    else $error("status code out of range");

  // A missing start code or a too short buffer clears every other field.
  a_fatal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:0] == ST_SHORT || out_tdata[3:0] == ST_NO_START)
    |-> out_tdata[OUT_TDATA_W-1:4] == '0)
    else $error("fields not cleared on early fatal status");

  // A result appears only after a final byte of a buffer was taken, through the input and result registers.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tlast, 2))
    else $error("result beat without a final input byte");

endmodule

bind radar_record_header_check rrhc_checker u_rrhc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
